>>> hdl/sprite_frame_sequencer_unit_defines.svh
// assertion macros of the sprite frame sequencer top level
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// condition and consequence in the same cycle
`define SFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sfs_pkg.sv
// shared types and constants of the sprite frame sequencer
package sfs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = FRAC_BITS + 1;
    localparam int STEP_BITS   = 4;
    localparam int DIV_STEPS   = FRAC_BITS / STEP_BITS;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 88;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAMES_W    = 12;
    localparam int FCOUNT_W    = 13;
    localparam logic [FCOUNT_W-1:0] FRAMES_LIMIT = 13'd4096;
    localparam logic [COORD_W-1:0]  ONE_FIXED    = 17'h10000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_ROWS,
        CFG_GRID_COLUMNS,
        CFG_START_ROW,
        CFG_START_COLUMN,
        CFG_FRAME_COUNT,
        CFG_FRAME_DELAY,
        CFG_PLAY_ENABLE,
        CFG_PAUSED
    } t_cfg_index;

    typedef enum logic {
        OP_TICK,
        OP_RESTART
    } t_op;

endpackage

>>> hdl/sfs_divider.sv
// shared fraction divider: (index << 16) / cells, four quotient bits per cycle
module sfs_divider import sfs_pkg::*; #(
    parameter int GRID_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [GRID_BITS:0]   i_index,
    input  logic [GRID_BITS:0]   i_cells,
    output logic                 o_done,
    output logic [COORD_W-1:0]   o_quot
);

    localparam int CW    = GRID_BITS + 1;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [CW-1:0]        r_rem;
    logic [CW-1:0]        r_cells;
    logic                 r_sat;
    logic [FRAC_BITS-1:0] r_quot;

    logic [CW-1:0]        n_rem;
    logic [STEP_BITS-1:0] n_bits;
    logic [CW:0]          n_trial;

    // restoring division, several dependent bits per cycle on narrow values
    always_comb begin
        n_rem   = r_rem;
        n_bits  = '0;
        n_trial = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            n_trial = {n_rem, 1'b0};
            if (n_trial >= {1'b0, r_cells}) begin
                n_trial = n_trial - {1'b0, r_cells};
                n_bits[STEP_BITS-1-k] = 1'b1;
            end
            n_rem = n_trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= i_index;
                r_cells <= i_cells;
                // a bound at or past the grid edge is one or saturates to one
                r_sat   <= (i_index >= i_cells);
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[FRAC_BITS-STEP_BITS-1:0], n_bits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? ONE_FIXED : {1'b0, r_quot};

endmodule

>>> hdl/sprite_frame_sequencer_unit.sv
// top level of the sprite-sheet frame sequencer
// Usage: items enter on the slave stream (tuser = operation, 0 tick, 1 restart;
// tdata = elapsed time). Each item yields exactly one result on the master
// stream with the current cell, its four texture bounds in 1.16 fixed point
// and a flag telling whether this tick moved to another frame.
// Configuration is written through the cfg channel (index, data), always
// ready; write it only while no item is in flight.
// Sequence: an item is taken in the idle state, then the accumulator update
// and the advance step each take a state, and four bound divisions run one
// after the other on one shared divider (start, steps of four quotient bits,
// done). The result register loads in the load state, and tready returns
// together with the loaded result, so no item is taken before it is loaded.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, the following result waits in
// the sequencer until the output register frees up.
// Reset: registers go to their defaults (grid 1 x 1, one frame, no delay,
// stopped, not paused), the cell, frame counter and accumulator clear.
module sprite_frame_sequencer_unit import sfs_pkg::*; #(
    parameter int TIME_BITS = 32,
    parameter int GRID_BITS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,   // [15:0] elapsed
    input  logic                   i_s_tuser,   // [0] operation
    // master stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [5:0] frame_row, [11:6] frame_column, [28:12] u_left, [45:29] u_right,
    // [62:46] v_top, [79:63] v_bottom, [80] frame_advanced, [87:81] zero
    output logic [M_TDATA_W-1:0]   o_m_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    `include "sprite_frame_sequencer_unit_defines.svh"

    localparam int CW = GRID_BITS + 1;
    localparam int GW = (CW > 7) ? CW : 7;
    localparam int unsigned GRID_LIM = 1 << GRID_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_STEP,
        S_DIV_START,
        S_DIV_WAIT,
        S_LOAD
    } t_state;

    typedef enum logic [1:0] {
        SEL_U_LEFT,
        SEL_U_RIGHT,
        SEL_V_TOP,
        SEL_V_BOTTOM
    } t_bound_sel;

    // configuration registers
    logic [6:0]          r_grid_rows;
    logic [6:0]          r_grid_columns;
    logic [5:0]          r_start_row;
    logic [5:0]          r_start_column;
    logic [FCOUNT_W-1:0] r_frame_count;
    logic [15:0]         r_frame_delay;
    logic                r_play_enable;
    logic                r_paused;

    // sequencer and animation state
    t_state              r_state;
    t_bound_sel          r_sel;
    t_op                 r_op;
    logic [15:0]         r_elapsed;
    logic [TIME_BITS-1:0] r_acc;
    logic [GRID_BITS-1:0] r_row;
    logic [GRID_BITS-1:0] r_col;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_moved;
    logic [COORD_W-1:0]  r_u_left;
    logic [COORD_W-1:0]  r_u_right;
    logic [COORD_W-1:0]  r_v_top;
    logic [COORD_W-1:0]  r_v_bottom;
    logic                r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic [TIME_BITS:0]   n_acc_sum;
    logic [TIME_BITS-1:0] n_acc;
    logic [GW-1:0]        n_cols_ext;
    logic [GW-1:0]        n_rows_ext;
    logic [CW-1:0]        n_cols;
    logic [CW-1:0]        n_rows;
    logic [FCOUNT_W-1:0]  n_fc;
    logic [FCOUNT_W-1:0]  n_next;
    logic [CW-1:0]        n_col_inc;
    logic [CW-1:0]        n_row_inc;
    logic                 n_do_step;
    logic [CW-1:0]        n_div_index;
    logic [CW-1:0]        n_div_cells;
    logic                 div_start;
    logic                 div_done;
    logic [COORD_W-1:0]   div_quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows    <= 7'd1;
            r_grid_columns <= 7'd1;
            r_start_row    <= '0;
            r_start_column <= '0;
            r_frame_count  <= FCOUNT_W'(1);
            r_frame_delay  <= '0;
            r_play_enable  <= 1'b0;
            r_paused       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[6:0];
                CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[6:0];
                CFG_START_ROW:    r_start_row    <= i_cfg_data[5:0];
                CFG_START_COLUMN: r_start_column <= i_cfg_data[5:0];
                CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[FCOUNT_W-1:0];
                CFG_FRAME_DELAY:  r_frame_delay  <= i_cfg_data;
                CFG_PLAY_ENABLE:  r_play_enable  <= i_cfg_data[0];
                CFG_PAUSED:       r_paused       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // grid sizes: zero counts as one, anything above the grid limit clamps
    always_comb begin
        n_cols_ext = GW'(r_grid_columns);
        n_rows_ext = GW'(r_grid_rows);
        if (n_cols_ext == '0) begin
            n_cols_ext = GW'(1);
        end else if (n_cols_ext > GW'(GRID_LIM)) begin
            n_cols_ext = GW'(GRID_LIM);
        end
        if (n_rows_ext == '0) begin
            n_rows_ext = GW'(1);
        end else if (n_rows_ext > GW'(GRID_LIM)) begin
            n_rows_ext = GW'(GRID_LIM);
        end
        n_cols = n_cols_ext[CW-1:0];
        n_rows = n_rows_ext[CW-1:0];
    end

    // saturating accumulate
    assign n_acc_sum = {1'b0, r_acc} + (TIME_BITS + 1)'(r_elapsed);
    assign n_acc     = n_acc_sum[TIME_BITS] ? '1 : n_acc_sum[TIME_BITS-1:0];

    assign n_fc      = (r_frame_count > FRAMES_LIMIT) ? FRAMES_LIMIT : r_frame_count;
    assign n_next    = FCOUNT_W'(r_frames) + 1'b1;
    assign n_col_inc = CW'(r_col) + 1'b1;
    assign n_row_inc = CW'(r_row) + 1'b1;
    assign n_do_step = !r_paused && r_play_enable
                    && (r_acc > TIME_BITS'(r_frame_delay));

    always_comb begin
        case (r_sel)
            SEL_U_LEFT: begin
                n_div_index = CW'(r_col);
                n_div_cells = n_cols;
            end
            SEL_U_RIGHT: begin
                n_div_index = n_col_inc;
                n_div_cells = n_cols;
            end
            SEL_V_TOP: begin
                n_div_index = CW'(r_row);
                n_div_cells = n_rows;
            end
            default: begin
                n_div_index = n_row_inc;
                n_div_cells = n_rows;
            end
        endcase
    end

    assign div_start = (r_state == S_DIV_START);

    sfs_divider #(
        .GRID_BITS (GRID_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_index (n_div_index),
        .i_cells (n_div_cells),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= SEL_U_LEFT;
            r_acc      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_frames   <= '0;
            r_moved    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // in the load state the freed register takes the new result
            if (r_m_tvalid && i_m_tready && r_state != S_LOAD) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op      <= t_op'(i_s_tuser);
                        r_elapsed <= i_s_tdata;
                        r_state   <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_op == OP_TICK && !r_paused) begin
                        r_acc <= n_acc;
                    end
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_moved <= (r_op != OP_RESTART) && n_do_step;
                    if (r_op == OP_RESTART) begin
                        r_acc    <= '0;
                        r_frames <= '0;
                        r_row    <= GRID_BITS'(r_start_row);
                        r_col    <= GRID_BITS'(r_start_column);
                    end else if (n_do_step) begin
                        r_acc   <= '0;
                        if (n_next < n_fc) begin
                            r_frames <= n_next[FRAMES_W-1:0];
                            // column wraps into the next row, last row wraps to zero
                            if (n_col_inc >= n_cols) begin
                                r_col <= '0;
                                if (n_row_inc >= n_rows) begin
                                    r_row <= '0;
                                end else begin
                                    r_row <= n_row_inc[GRID_BITS-1:0];
                                end
                            end else begin
                                r_col <= n_col_inc[GRID_BITS-1:0];
                            end
                        end else begin
                            r_frames <= '0;
                            r_row    <= GRID_BITS'(r_start_row);
                            r_col    <= GRID_BITS'(r_start_column);
                        end
                    end
                    r_sel   <= SEL_U_LEFT;
                    r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        case (r_sel)
                            SEL_U_LEFT:  r_u_left   <= div_quot;
                            SEL_U_RIGHT: r_u_right  <= div_quot;
                            SEL_V_TOP:   r_v_top    <= div_quot;
                            default:     r_v_bottom <= div_quot;
                        endcase
                        if (r_sel == SEL_V_BOTTOM) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_sel   <= t_bound_sel'(r_sel + 1'b1);
                            r_state <= S_DIV_START;
                        end
                    end
                end
                S_LOAD: begin
                    if (!r_m_tvalid || i_m_tready) begin
                        r_m_tdata  <= {7'd0, r_moved, r_v_bottom, r_v_top,
                                       r_u_right, r_u_left, 6'(r_col), 6'(r_row)};
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    `SFS_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == S_DIV_WAIT, "divider finished outside the wait state")
    `SFS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, r_state == S_STEP && r_op == OP_RESTART, r_acc == '0 && r_frames == '0, "restart left counters set")
    `SFS_ASSERT_NOW(a_result_from_load, i_clk, i_rst_n, $rose(r_m_tvalid), $past(r_state) == S_LOAD, "result appeared outside the load state")

endmodule

>>> tb/tb_sprite_frame_sequencer_unit.sv
// testbench for the sprite-sheet frame sequencer: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_unit;
    import sfs_pkg::*;

    typedef struct packed {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [16:0] u_left;
        logic [16:0] u_right;
        logic [16:0] v_top;
        logic [16:0] v_bottom;
        logic        advanced;
    } t_frame_view;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    t_cfg_index             cfg_index = CFG_GRID_ROWS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_ready;

    // shadow of the configuration registers
    logic [6:0]  set_rows = 7'd1;
    logic [6:0]  set_cols = 7'd1;
    logic [5:0]  set_start_row = '0;
    logic [5:0]  set_start_col = '0;
    logic [12:0] set_frame_count = 13'd1;
    logic [15:0] set_delay = '0;
    logic        set_play = 1'b0;
    logic        set_paused = 1'b0;

    // predicted animation state
    logic [31:0] acc_time = '0;
    logic [5:0]  cur_row = '0;
    logic [5:0]  cur_col = '0;
    logic [11:0] played = '0;

    t_frame_view pending_views[$];
    int          mismatches = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          stall_left = 0;

    sprite_frame_sequencer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_sprite_frame_sequencer_unit failed");
        $finish;
    end

    // zero means one cell, anything past 64 means 64
    function automatic logic [6:0] grid_cells(logic [6:0] setting);
        if (setting == 7'd0)
            return 7'd1;
        return (setting > 7'd64) ? 7'd64 : setting;
    endfunction

    function automatic logic [16:0] texture_edge(logic [6:0] index, logic [6:0] cells);
        int unsigned q;
        q = (int'(index) << 16) / int'(cells);
        return (q > 65536) ? ONE_FIXED : q[16:0];
    endfunction

    function automatic t_frame_view predict_frame(t_op op, logic [15:0] elapsed);
        t_frame_view v;
        logic [32:0] sum;
        logic [12:0] loop_len;
        logic [12:0] next_count;
        logic [6:0]  cols;
        logic [6:0]  rows;
        cols = grid_cells(set_cols);
        rows = grid_cells(set_rows);
        v.advanced = 1'b0;
        if (op == OP_RESTART) begin
            acc_time = '0;
            played = '0;
            cur_row = set_start_row;
            cur_col = set_start_col;
        end else if (!set_paused) begin
            sum = {1'b0, acc_time} + 33'(elapsed);
            acc_time = sum[32] ? '1 : sum[31:0];
            if (acc_time > 32'(set_delay) && set_play) begin
                loop_len = (set_frame_count > FRAMES_LIMIT) ? FRAMES_LIMIT : set_frame_count;
                next_count = {1'b0, played} + 13'd1;
                if (next_count < loop_len) begin
                    played = next_count[11:0];
                    if ({1'b0, cur_col} + 7'd1 >= cols) begin
                        cur_col = '0;
                        if ({1'b0, cur_row} + 7'd1 >= rows)
                            cur_row = '0;
                        else
                            cur_row = cur_row + 6'd1;
                    end else begin
                        cur_col = cur_col + 6'd1;
                    end
                end else begin
                    cur_row = set_start_row;
                    cur_col = set_start_col;
                    played = '0;
                end
                acc_time = '0;
                v.advanced = 1'b1;
            end
        end
        v.row = cur_row;
        v.col = cur_col;
        v.u_left = texture_edge({1'b0, cur_col}, cols);
        v.u_right = texture_edge({1'b0, cur_col} + 7'd1, cols);
        v.v_top = texture_edge({1'b0, cur_row}, rows);
        v.v_bottom = texture_edge({1'b0, cur_row} + 7'd1, rows);
        return v;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_frame_view want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_views.size() == 0) begin
                $error("result with no item pending: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                compare_field("frame_row", 32'(want.row), 32'(m_tdata[5:0]));
                compare_field("frame_column", 32'(want.col), 32'(m_tdata[11:6]));
                compare_field("u_left", 32'(want.u_left), 32'(m_tdata[28:12]));
                compare_field("u_right", 32'(want.u_right), 32'(m_tdata[45:29]));
                compare_field("v_top", 32'(want.v_top), 32'(m_tdata[62:46]));
                compare_field("v_bottom", 32'(want.v_bottom), 32'(m_tdata[79:63]));
                compare_field("frame_advanced", 32'(want.advanced), 32'(m_tdata[80]));
            end
        end
    end

    // receiver drops tready in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // returns right after the accepting edge; the next call or stream_idle drives valid
    task automatic send_item(t_op op, logic [15:0] elapsed);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= elapsed;
        s_tuser <= op;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pending_views.push_back(predict_frame(op, elapsed));
    endtask

    task automatic stream_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stream_idle();
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_GRID_ROWS:    set_rows = value[6:0];
            CFG_GRID_COLUMNS: set_cols = value[6:0];
            CFG_START_ROW:    set_start_row = value[5:0];
            CFG_START_COLUMN: set_start_col = value[5:0];
            CFG_FRAME_COUNT:  set_frame_count = value[12:0];
            CFG_FRAME_DELAY:  set_delay = value;
            CFG_PLAY_ENABLE:  set_play = value[0];
            CFG_PAUSED:       set_paused = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [15:0] rows, logic [15:0] cols, logic [15:0] srow,
                                 logic [15:0] scol, logic [15:0] fcount, logic [15:0] delay,
                                 logic [15:0] play, logic [15:0] pause);
        wait_drained();
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_GRID_COLUMNS, cols);
        write_reg(CFG_START_ROW, srow);
        write_reg(CFG_START_COLUMN, scol);
        write_reg(CFG_FRAME_COUNT, fcount);
        write_reg(CFG_FRAME_DELAY, delay);
        write_reg(CFG_PLAY_ENABLE, play);
        write_reg(CFG_PAUSED, pause);
    endtask

    task automatic test_reset_defaults();
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_RESTART, 16'hFFFF);
    endtask

    // 3 x 4 grid, loop of five frames starting at row 1 column 2
    task automatic test_grid_walk();
        apply_setting(16'd3, 16'd4, 16'd1, 16'd2, 16'd5, 16'd10, 16'd1, 16'd0);
        send_item(OP_TICK, 16'd10);
        send_item(OP_TICK, 16'd1);
        send_item(OP_TICK, 16'd11);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_RESTART, 16'd0);
    endtask

    task automatic test_pause_and_hold();
        apply_setting(16'd2, 16'd2, 16'd0, 16'd1, 16'd3, 16'd0, 16'd0, 16'd1);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_RESTART, 16'd0);
        // stopped: time piles up past the largest delay without moving the cell
        apply_setting(16'd2, 16'd2, 16'd0, 16'd1, 16'd3, 16'd0, 16'd0, 16'd0);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_TICK, 16'hFFFF);
        apply_setting(16'd2, 16'd2, 16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd1, 16'd0);
        send_item(OP_TICK, 16'd0);
    endtask

    task automatic test_odd_settings();
        // zero rows, oversized columns, zero loop length, start past the grid
        apply_setting(16'hFF80, 16'd127, 16'd63, 16'hFFFF, 16'd0, 16'd0, 16'hFFFE, 16'd0);
        send_item(OP_TICK, 16'd1);
        send_item(OP_TICK, 16'd1);
        send_item(OP_RESTART, 16'd5);
        // loop length above the limit, single column, start column past it
        apply_setting(16'd127, 16'd0, 16'd62, 16'hFFC0 | 16'd63, 16'hFFFF, 16'd0,
                      16'd1, 16'hFFFE);
        send_item(OP_RESTART, 16'd0);
        send_item(OP_TICK, 16'd1);
        send_item(OP_TICK, 16'd1);
        send_item(OP_TICK, 16'd1);
    endtask

    task automatic random_setting();
        logic [15:0] rows;
        logic [15:0] cols;
        logic [15:0] fcount;
        logic [15:0] delay;
        logic [15:0] srow;
        logic [15:0] scol;
        case ($urandom_range(0, 7))
            0: rows = 16'd0;
            1: rows = 16'd64;
            2: rows = 16'($urandom_range(65, 127));
            3: rows = 16'($urandom);
            default: rows = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0: cols = 16'd0;
            1: cols = 16'd64;
            2: cols = 16'($urandom_range(65, 127));
            3: cols = 16'($urandom);
            default: cols = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0: fcount = 16'd0;
            1: fcount = 16'd4096;
            2: fcount = 16'($urandom);
            3: fcount = 16'd1;
            default: fcount = 16'($urandom_range(2, 40));
        endcase
        case ($urandom_range(0, 5))
            0: delay = 16'd0;
            1: delay = 16'hFFFF;
            2: delay = 16'($urandom);
            default: delay = 16'($urandom_range(1, 50));
        endcase
        srow = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        scol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        apply_setting(rows, cols, srow, scol, fcount, delay,
                      16'($urandom_range(0, 7) != 0), 16'($urandom_range(0, 9) == 0));
    endtask

    task automatic random_items(int count, bit hold_midway);
        int unsigned span;
        logic [15:0] elapsed;
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2)
                wait_drained();
            span = (int'(set_delay) * 2 + 2 > 65535) ? 65535 : int'(set_delay) * 2 + 2;
            case ($urandom_range(0, 5))
                0: elapsed = 16'd0;
                1: elapsed = 16'hFFFF;
                2, 3: elapsed = 16'($urandom_range(0, span));
                default: elapsed = 16'($urandom);
            endcase
            send_item(($urandom_range(0, 11) == 0) ? OP_RESTART : OP_TICK, elapsed);
        end
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 20; phase++) begin
            random_setting();
            random_items(55, phase == 5);
        end
    endtask

    task automatic test_full_rate();
        random_setting();
        @(posedge i_clk);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_items(50, 1'b0);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_grid_walk();
        test_pause_and_hold();
        test_odd_settings();
        test_random_phases();
        test_full_rate();
        wait_drained();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb_sprite_frame_sequencer_unit passed");
        else
            $display("tb_sprite_frame_sequencer_unit failed");
        $finish;
    end

endmodule
